>>> sv/mofb_pkg.sv
package mofb_pkg;

    // Width of one half of the cipher block
    localparam int unsigned HALF_W = 32;

    // Rotate distance of the round function
    localparam int unsigned ROT = 11;

    // Rounds that take the key words in forward order
    localparam int unsigned KEY_FWD_ROUNDS = 24;

    // Bytes in one data block
    localparam int unsigned BLOCK_BYTES = 8;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_KEY01 = 3'd0,
        REG_KEY23 = 3'd1,
        REG_KEY45 = 3'd2,
        REG_KEY67 = 3'd3,
        REG_IV    = 3'd4
    } reg_idx_t;

    // State handed from one round cell to the next
    typedef struct packed {
        logic              valid;
        logic [HALF_W-1:0] lo;
        logic [HALF_W-1:0] hi;
    } cell_bus_t;

    // Substitution boxes, box n serves nibble n (nibble 0 lowest)
    localparam logic [3:0] SBOX [8][16] = '{
        '{4'hC, 4'h4, 4'h6, 4'h2, 4'hA, 4'h5, 4'hB, 4'h9,
          4'hE, 4'h8, 4'hD, 4'h7, 4'h0, 4'h3, 4'hF, 4'h1},
        '{4'h6, 4'h8, 4'h2, 4'h3, 4'h9, 4'hA, 4'h5, 4'hC,
          4'h1, 4'hE, 4'h4, 4'h7, 4'hB, 4'hD, 4'h0, 4'hF},
        '{4'hB, 4'h3, 4'h5, 4'h8, 4'h2, 4'hF, 4'hA, 4'hD,
          4'hE, 4'h1, 4'h7, 4'h4, 4'hC, 4'h9, 4'h6, 4'h0},
        '{4'hC, 4'h8, 4'h2, 4'h1, 4'hD, 4'h4, 4'hF, 4'h6,
          4'h7, 4'h0, 4'hA, 4'h5, 4'h3, 4'hE, 4'h9, 4'hB},
        '{4'h7, 4'hF, 4'h5, 4'hA, 4'h8, 4'h1, 4'h6, 4'hD,
          4'h0, 4'h9, 4'h3, 4'hE, 4'hB, 4'h4, 4'h2, 4'hC},
        '{4'h5, 4'hD, 4'hF, 4'h6, 4'h9, 4'h2, 4'hC, 4'hA,
          4'hB, 4'h7, 4'h8, 4'h1, 4'h4, 4'h3, 4'hE, 4'h0},
        '{4'h8, 4'hE, 4'h2, 4'h5, 4'h6, 4'h9, 4'h1, 4'hC,
          4'hF, 4'h4, 4'hB, 4'h0, 4'hD, 4'hA, 4'h3, 4'h7},
        '{4'h1, 4'h7, 4'hE, 4'hD, 4'h0, 4'h5, 4'h8, 4'h3,
          4'h4, 4'hF, 4'hA, 4'h6, 4'h9, 4'hC, 4'hB, 4'h2}
    };

    // Round function: add key, substitute nibbles, rotate left
    function automatic logic [HALF_W-1:0] mix_word(input logic [HALF_W-1:0] half,
                                                   input logic [HALF_W-1:0] rk);
        logic [HALF_W-1:0] sum;
        logic [HALF_W-1:0] sub;
        sum = half + rk;
        sub = '0;
        for (int n = 0; n < 8; n++) begin
            sub[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
        end
        return {sub[HALF_W-1-ROT:0], sub[HALF_W-1:HALF_W-ROT]};
    endfunction

endpackage

>>> sv/mofb_cfg_regs.sv
module mofb_cfg_regs (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [2:0]                            cfg_index,
    input  logic [63:0]                           cfg_data,
    output logic [7:0][mofb_pkg::HALF_W-1:0]      key_words,
    output logic [63:0]                           iv_value
);

    logic [3:0][63:0] key_pair_reg;
    logic [63:0]      iv_reg;

    assign cfg_ready = 1'b1;

    // Split the pairs into eight key words
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            key_words[2*p]   = key_pair_reg[p][31:0];
            key_words[2*p+1] = key_pair_reg[p][63:32];
        end
    end

    assign iv_value = iv_reg;

    // Decode a write request; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_pair_reg <= '0;
            iv_reg       <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (mofb_pkg::reg_idx_t'(cfg_index))
                mofb_pkg::REG_KEY01: key_pair_reg[0] <= cfg_data;
                mofb_pkg::REG_KEY23: key_pair_reg[1] <= cfg_data;
                mofb_pkg::REG_KEY45: key_pair_reg[2] <= cfg_data;
                mofb_pkg::REG_KEY67: key_pair_reg[3] <= cfg_data;
                mofb_pkg::REG_IV:    iv_reg          <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

>>> sv/mofb_round_cell.sv
module mofb_round_cell #(
    parameter bit LAST_ROUND = 1'b0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  mofb_pkg::cell_bus_t           in_bus,
    input  logic [mofb_pkg::HALF_W-1:0]   round_key,
    output mofb_pkg::cell_bus_t           out_bus
);

    mofb_pkg::cell_bus_t      bus_reg;
    mofb_pkg::cell_bus_t      bus_next;
    logic [mofb_pkg::HALF_W-1:0] t;

    // One Feistel round; the last round keeps the halves in place
    always_comb begin
        t              = in_bus.hi ^ mofb_pkg::mix_word(in_bus.lo, round_key);
        bus_next.valid = in_bus.valid;
        if (LAST_ROUND) begin
            bus_next.lo = in_bus.lo;
            bus_next.hi = t;
        end else begin
            bus_next.lo = t;
            bus_next.hi = in_bus.lo;
        end
    end

    // Hand the state on while the chain advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bus_reg.valid <= 1'b0;
        end else if (advance) begin
            bus_reg <= bus_next;
        end
    end

    assign out_bus = bus_reg;

endmodule

>>> sv/magma_ofb_keystream.sv
// Magma OFB keystream block.
// s_ channel takes data blocks: s_tdata carries the 64-bit data and the byte
// count, s_tuser carries the restart flag, which reloads the feedback from the
// IV before the block. m_ channel returns the block XOR keystream with bytes
// past the count cleared, plus the count (saturated at eight).
// cfg_ channel writes the four key pairs and the IV; the user must do so only
// while the block is idle; the block does not enforce it. A block runs through
// a row of 32 round cells, one round per cycle unless the output stalls; since
// each keystream block is the cipher of the last, one block is in the row at a
// time. A block accepted while idle passes the pending slot, the round cells
// and the output register to m_tdata; back-to-back blocks are paced by the
// round chain. One further block may be accepted and held while another is
// being enciphered. Reset clears the feedback, the keys, the IV and all valid
// flags; there is no clearing pass. When the receiver stalls, the finished
// result holds in the output register and the round row holds its next result
// in the last cell until the output register frees.
module magma_ofb_keystream #(
    parameter int unsigned ROUND_COUNT = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // data_block [63:0], byte_count [67:64], zero fill [71:68]
    input  logic [71:0] s_tdata,
    // restart [0]
    input  logic [0:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // out_block [63:0], out_count [67:64], zero fill [71:68]
    output logic [71:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int unsigned HW = mofb_pkg::HALF_W;

    logic [7:0][HW-1:0] key_words;
    logic [63:0]        iv_value;

    // Pending request slot
    logic        pend_valid_reg, pend_valid_next;
    logic [63:0] pend_data_reg;
    logic [3:0]  pend_count_reg;
    logic        pend_restart_reg;

    // Block in the round chain
    logic [63:0] act_data_reg;
    logic [3:0]  act_count_reg;
    logic [3:0]  sat_count;

    // Feedback and output
    logic [63:0] feedback_reg, feedback_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_block_reg;
    logic [3:0]  out_count_reg;

    mofb_pkg::cell_bus_t chain_in  [ROUND_COUNT];
    mofb_pkg::cell_bus_t chain_out [ROUND_COUNT];

    logic        advance;
    logic        finish;
    logic        busy;
    logic        issue;
    logic [63:0] start_block;
    logic [63:0] cipher_block;
    logic [63:0] byte_mask;

    mofb_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_words (key_words),
        .iv_value  (iv_value)
    );

    // Hold the chain while a finished result cannot leave
    assign advance = !(chain_out[ROUND_COUNT-1].valid && out_valid_reg && !m_tready);
    assign finish  = chain_out[ROUND_COUNT-1].valid && advance;

    // Chain busy apart from the last cell
    always_comb begin
        busy = 1'b0;
        for (int r = 0; r < ROUND_COUNT - 1; r++) begin
            busy = busy | chain_out[r].valid;
        end
    end

    assign cipher_block  = {chain_out[ROUND_COUNT-1].hi, chain_out[ROUND_COUNT-1].lo};
    assign feedback_next = finish ? cipher_block : feedback_reg;
    assign issue         = pend_valid_reg && advance && !busy;
    assign start_block   = pend_restart_reg ? iv_value : feedback_next;

    // Feed the first cell: valid, low word, high word
    assign chain_in[0] = {issue, start_block[HW-1:0], start_block[63:HW]};

    // Row of round cells
    for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
        localparam int unsigned POS = r % 8;
        localparam int unsigned KI  = (r < mofb_pkg::KEY_FWD_ROUNDS) ? POS : 7 - POS;
        localparam logic [2:0]  KEY_SEL = 3'(KI);

        if (r > 0) begin : g_link
            assign chain_in[r] = chain_out[r-1];
        end

        mofb_round_cell #(
            .LAST_ROUND (r == ROUND_COUNT - 1)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_bus    (chain_in[r]),
            .round_key (key_words[KEY_SEL]),
            .out_bus   (chain_out[r])
        );
    end

    // Take a request while the slot is free
    assign s_tready = !pend_valid_reg;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        if (s_tvalid && s_tready) begin
            pend_valid_next = 1'b1;
        end else if (issue) begin
            pend_valid_next = 1'b0;
        end
    end

    // Saturate the count at a full block
    assign sat_count = (pend_count_reg > 4'(mofb_pkg::BLOCK_BYTES))
                       ? 4'(mofb_pkg::BLOCK_BYTES) : pend_count_reg;

    // Keep the low bytes that the count covers
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            byte_mask[8*j +: 8] = (4'(j) < act_count_reg) ? 8'hFF : 8'h00;
        end
    end

    // Load the output register on finish, drop it when taken
    always_comb begin
        out_valid_next = out_valid_reg;
        if (finish) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            feedback_reg   <= '0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            feedback_reg   <= feedback_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pend_data_reg    <= s_tdata[63:0];
            pend_count_reg   <= s_tdata[67:64];
            pend_restart_reg <= s_tuser[0];
        end
        if (issue) begin
            act_data_reg  <= pend_data_reg;
            act_count_reg <= sat_count;
        end
        if (finish) begin
            out_block_reg <= (act_data_reg ^ cipher_block) & byte_mask;
            out_count_reg <= act_count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_count_reg, out_block_reg};

endmodule
